[hdl/chess_piece_attack_generator_defines.svh]
// ---------------------------------------------------------------------------
// chess_piece_attack_generator_defines.svh
// Assertion macros for the attack generator.
// ---------------------------------------------------------------------------
`ifndef CHESS_PIECE_ATTACK_GENERATOR_DEFINES_SVH
`define CHESS_PIECE_ATTACK_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define CPAG_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("attack generator assertion failed");

// Next-cycle implication.
`define CPAG_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("attack generator assertion failed");

`else

`define CPAG_ASSERT_IMP(label, clk, rst, ante, cons)
`define CPAG_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

[hdl/cpag_pkg.sv]
// ---------------------------------------------------------------------------
// cpag_pkg
// Mode codes, board masks and bitboard step / fill functions.
// ---------------------------------------------------------------------------
package cpag_pkg;

  localparam int unsigned BoardBits  = 64;
  localparam int unsigned SquareBits = 6;
  localparam int unsigned ModeBits   = 3;

  typedef logic [BoardBits-1:0]  board_t;
  typedef logic [SquareBits-1:0] square_t;
  typedef logic [ModeBits-1:0]   mode_t;

  localparam mode_t MODE_ROOK       = 3'd0;
  localparam mode_t MODE_BISHOP     = 3'd1;
  localparam mode_t MODE_QUEEN      = 3'd2;
  localparam mode_t MODE_KNIGHT     = 3'd3;
  localparam mode_t MODE_KING       = 3'd4;
  localparam mode_t MODE_WHITE_PAWN = 3'd5;
  localparam mode_t MODE_BLACK_PAWN = 3'd6;
  localparam mode_t MODE_UNUSED     = 3'd7;

  localparam board_t FILE_A = 64'h0101_0101_0101_0101;
  localparam board_t FILE_H = 64'h8080_8080_8080_8080;
  localparam board_t NOT_A  = ~FILE_A;
  localparam board_t NOT_H  = ~FILE_H;

  // Single steps with file-wrap masking.
  function automatic board_t step_n(input board_t b);
    return b << 8;
  endfunction
  function automatic board_t step_s(input board_t b);
    return b >> 8;
  endfunction
  function automatic board_t step_e(input board_t b);
    return (b & NOT_H) << 1;
  endfunction
  function automatic board_t step_w(input board_t b);
    return (b & NOT_A) >> 1;
  endfunction
  function automatic board_t step_ne(input board_t b);
    return (b & NOT_H) << 9;
  endfunction
  function automatic board_t step_nw(input board_t b);
    return (b & NOT_A) << 7;
  endfunction
  function automatic board_t step_se(input board_t b);
    return (b & NOT_H) >> 7;
  endfunction
  function automatic board_t step_sw(input board_t b);
    return (b & NOT_A) >> 9;
  endfunction

  // Kogge-Stone occluded fill: three doubling steps (s, 2s, 4s).
  // up and s are constant at every call, so each shift is plain wiring.
  function automatic board_t occl_fill(input board_t gen_in, input board_t pro_in,
                                       input logic up, input int unsigned s);
    board_t gen;
    board_t pro;
    int unsigned d;
    gen = gen_in;
    pro = pro_in;
    for (int k = 0; k < 3; k++) begin
      d = s << k;
      if (up) begin
        gen = gen | (pro & (gen << d));
        pro = pro & (pro << d);
      end else begin
        gen = gen | (pro & (gen >> d));
        pro = pro & (pro >> d);
      end
    end
    return gen;
  endfunction

endpackage

[hdl/cpag_slider.sv]
// ---------------------------------------------------------------------------
// cpag_slider
// Rook and bishop ray sets from eight parallel occluded fills.
// ---------------------------------------------------------------------------
module cpag_slider
  import cpag_pkg::*;
(
  input  board_t occupancy,
  input  board_t origin,
  output board_t rook_set,
  output board_t bishop_set
);

  board_t empty;

  assign empty = ~occupancy;

  // Each ray keeps its first blocker: fill through empties, then one more step.
  assign rook_set = step_n(occl_fill(origin, empty, 1'b1, 8))
                  | step_s(occl_fill(origin, empty, 1'b0, 8))
                  | step_e(occl_fill(origin, empty & NOT_A, 1'b1, 1))
                  | step_w(occl_fill(origin, empty & NOT_H, 1'b0, 1));

  assign bishop_set = step_ne(occl_fill(origin, empty & NOT_A, 1'b1, 9))
                    | step_nw(occl_fill(origin, empty & NOT_H, 1'b1, 7))
                    | step_se(occl_fill(origin, empty & NOT_A, 1'b0, 7))
                    | step_sw(occl_fill(origin, empty & NOT_H, 1'b0, 9));

endmodule

[hdl/cpag_leaper.sv]
// ---------------------------------------------------------------------------
// cpag_leaper
// Fixed knight, king and pawn patterns, selected by mode.
// ---------------------------------------------------------------------------
module cpag_leaper
  import cpag_pkg::*;
(
  input  board_t origin,
  input  mode_t  mode,
  output board_t leap_set
);

  board_t w1, e1, w2, e2, one, two;
  board_t knight_set, row, king_all;

  assign w1  = step_w(origin);
  assign e1  = step_e(origin);
  assign w2  = step_w(w1);
  assign e2  = step_e(e1);
  assign one = w1 | e1;
  assign two = w2 | e2;

  assign knight_set = (one << 16) | (one >> 16) | (two << 8) | (two >> 8);

  assign row      = origin | e1 | w1;
  assign king_all = row | step_n(row) | step_s(row);

  always_comb begin
    case (mode)
      MODE_KNIGHT:     leap_set = knight_set;
      MODE_KING:       leap_set = king_all & ~origin;
      MODE_WHITE_PAWN: leap_set = step_ne(origin) | step_nw(origin);
      MODE_BLACK_PAWN: leap_set = step_se(origin) | step_sw(origin);
      default:         leap_set = '0;
    endcase
  end

endmodule

[hdl/chess_piece_attack_generator.sv]
// A start edge loads the input register stage; done and attack_set come from the result register.
// Throughput: one transaction per cycle; busy is always low.
// The rate is set by one shallow fill network between input and result registers.
// Reset (rst, synchronous, active high) clears the valid pipeline; no done
// strobes follow until new transactions arrive. Results cannot be stalled.
// ---------------------------------------------------------------------------
// chess_piece_attack_generator
// Attack set of one piece on a 64-square board: Kogge-Stone sliding rays
// for rook/bishop/queen, fixed patterns for knight, king and pawns.
// ---------------------------------------------------------------------------
`include "chess_piece_attack_generator_defines.svh"

module chess_piece_attack_generator
  import cpag_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  // command side
  input  logic    start,
  output logic    busy,
  input  board_t  occupancy,
  input  square_t square,
  input  mode_t   mode,
  // result side: one-cycle strobe, no backpressure
  output logic    done,
  output board_t  attack_set
);

  // Input register stage.
  logic    in_valid;
  board_t  occ_q;
  square_t sq_q;
  mode_t   mode_q;

  // Combinational result.
  board_t origin;
  board_t rook_set;
  board_t bishop_set;
  board_t leap_set;
  board_t attack_next;

  // Mode qualifiers for the checks below.
  logic unused_q;
  logic leaper_q;

  // Never stalls: every cycle can take a new transaction.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (start) begin
      occ_q  <= occupancy;
      sq_q   <= square;
      mode_q <= mode;
    end
  end

  // One-hot origin square. The origin's own occupancy bit does not matter:
  // fills start from the origin either way.
  assign origin = board_t'(1) << sq_q;

  cpag_slider u_slider (
    .occupancy  (occ_q),
    .origin     (origin),
    .rook_set   (rook_set),
    .bishop_set (bishop_set)
  );

  cpag_leaper u_leaper (
    .origin   (origin),
    .mode     (mode_q),
    .leap_set (leap_set)
  );

  // Queen is the union of both slider sets; unused mode gives an empty set
  // through the leaper's default arm.
  always_comb begin
    case (mode_q)
      MODE_ROOK:   attack_next = rook_set;
      MODE_BISHOP: attack_next = bishop_set;
      MODE_QUEEN:  attack_next = rook_set | bishop_set;
      default:     attack_next = leap_set;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      attack_set <= attack_next;
    end
  end

  assign unused_q = in_valid && (mode_q == MODE_UNUSED);
  assign leaper_q = in_valid && ((mode_q == MODE_KNIGHT) || (mode_q == MODE_KING));

  // Every accepted transaction yields exactly one strobe, through the input and result registers.
  `CPAG_ASSERT_NXT(a_start_to_done, clk, rst, start, ##1 done)
  `CPAG_ASSERT_IMP(a_done_from_start, clk, rst, done, $past(start, 2))
  // Unused mode must produce an empty set.
  `CPAG_ASSERT_NXT(a_unused_empty, clk, rst, unused_q, attack_set == '0)
  // Leapers reach at most eight squares.
  `CPAG_ASSERT_NXT(a_leaper_count, clk, rst, leaper_q, $countones(attack_set) <= 8)

endmodule

[tb/attack_checker.sv]
// ---------------------------------------------------------------------------
// attack_checker
// Watches the command and result sides of the attack generator. It predicts
// the attack set of each accepted transaction by walking rays square by
// square, and compares it in order with the done strobes.
// ---------------------------------------------------------------------------
module attack_checker
  import cpag_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    busy,
  input  board_t  occupancy,
  input  square_t square,
  input  mode_t   mode,
  input  logic    done,
  input  board_t  attack_set,
  output int      fail_count,
  output int      outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    board_t  occ;
    square_t sq;
    mode_t   md;
    board_t  attacks;
  } query_t;

  query_t expected_attacks[$];
  query_t oldest;

  // Squares reached from sq stepping (df, dr) until the edge or the first
  // occupied square, which is included. With every square occupied this is
  // a single leaper step.
  function automatic board_t ray_squares(input board_t occ, input square_t sq,
                                         input int df, input int dr);
    board_t acc;
    int f;
    int r;
    acc = '0;
    f = int'(sq) % 8 + df;
    r = int'(sq) / 8 + dr;
    while (f >= 0 && f < 8 && r >= 0 && r < 8) begin
      acc[r*8+f] = 1'b1;
      if (occ[r*8+f]) break;
      f += df;
      r += dr;
    end
    return acc;
  endfunction

  function automatic board_t attacked_squares(input board_t occ, input square_t sq,
                                              input mode_t md);
    board_t all_occ;
    board_t orth;
    board_t diag;
    board_t res;
    all_occ = '1;
    orth = ray_squares(occ, sq, 0, 1) | ray_squares(occ, sq, 0, -1) |
           ray_squares(occ, sq, 1, 0) | ray_squares(occ, sq, -1, 0);
    diag = ray_squares(occ, sq, 1, 1) | ray_squares(occ, sq, -1, 1) |
           ray_squares(occ, sq, 1, -1) | ray_squares(occ, sq, -1, -1);
    res = '0;
    case (md)
      MODE_ROOK:   res = orth;
      MODE_BISHOP: res = diag;
      MODE_QUEEN:  res = orth | diag;
      MODE_KNIGHT: begin
        for (int a = -2; a <= 2; a++) begin
          for (int b = -2; b <= 2; b++) begin
            if (a * a + b * b == 5) res |= ray_squares(all_occ, sq, a, b);
          end
        end
      end
      MODE_KING: begin
        for (int a = -1; a <= 1; a++) begin
          for (int b = -1; b <= 1; b++) begin
            if (a != 0 || b != 0) res |= ray_squares(all_occ, sq, a, b);
          end
        end
      end
      MODE_WHITE_PAWN: res = ray_squares(all_occ, sq, 1, 1) | ray_squares(all_occ, sq, -1, 1);
      MODE_BLACK_PAWN: res = ray_squares(all_occ, sq, 1, -1) | ray_squares(all_occ, sq, -1, -1);
      default:         res = '0;
    endcase
    return res;
  endfunction

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (expected_attacks.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual %h", $time, attack_set);
        end else begin
          oldest = expected_attacks.pop_front();
          if (attack_set !== oldest.attacks) begin
            fail_count++;
            $display("%0t: attack_set mismatch sq=%0d mode=%0d occ=%h expected %h actual %h",
                     $time, oldest.sq, oldest.md, oldest.occ, oldest.attacks, attack_set);
          end
        end
      end
      if (start && !busy) begin
        expected_attacks.push_back('{occupancy, square, mode,
                                     attacked_squares(occupancy, square, mode)});
      end
    end
    outstanding = expected_attacks.size();
  end

endmodule

[tb/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the chess piece attack generator: directed
// corner and edge transactions, then random boards, squares and modes with
// bursts of idle cycles. Checking is done by attack_checker.
// ---------------------------------------------------------------------------
module tb
  import cpag_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Far above the slowest run of roughly 725 transactions with their longest idle gaps.
  localparam int CycleLimit = 200000;
  // Pipeline is the input and result registers; the tail also catches stray strobes.
  localparam int TailCycles = 4;

  logic    clk       = 1'b0;
  logic    rst       = 1'b1;
  logic    start     = 1'b0;
  board_t  occupancy = '0;
  square_t square    = '0;
  mode_t   mode      = MODE_ROOK;
  logic    busy;
  logic    done;
  board_t  attack_set;

  int fail_count;
  int outstanding;
  int cycle_count = 0;

  always #2 clk = ~clk;

  chess_piece_attack_generator dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .occupancy  (occupancy),
    .square     (square),
    .mode       (mode),
    .done       (done),
    .attack_set (attack_set)
  );

  attack_checker chk (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .occupancy   (occupancy),
    .square      (square),
    .mode        (mode),
    .done        (done),
    .attack_set  (attack_set),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Present one transaction and hold it until the edge that accepts it.
  // start stays high on return so back-to-back transactions need no gap.
  task automatic issue(input board_t occ, input square_t sq, input mode_t md);
    start     <= 1'b1;
    occupancy <= occ;
    square    <= sq;
    mode      <= md;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold off until every predicted result has come back.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    board_t  occ;
    square_t sq;
    mode_t   md;
    bit      quiet;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // --- directed part -----------------------------------------------------
    // Sliders on an empty and a full board, corners and both colors of
    // diagonal, origin bit set on an otherwise empty board.
    issue(64'h0, 6'd0, MODE_ROOK);
    issue(64'hFFFF_FFFF_FFFF_FFFF, 6'd63, MODE_ROOK);
    issue(64'hAAAA_AAAA_AAAA_AAAA, 6'd7, MODE_ROOK);
    issue(64'h0, 6'd7, MODE_BISHOP);
    issue(64'hFFFF_FFFF_FFFF_FFFF, 6'd56, MODE_BISHOP);
    issue(64'h5555_5555_5555_5555, 6'd28, MODE_BISHOP);
    issue(64'h0, 6'd27, MODE_QUEEN);
    issue(64'h1 << 36, 6'd36, MODE_QUEEN);
    issue(64'hFFFF_FFFF_FFFF_FFFF, 6'd0, MODE_QUEEN);
    // Leapers: corners clip the pattern, center gets the full set.
    issue(64'h0, 6'd0, MODE_KNIGHT);
    issue(64'h0, 6'd63, MODE_KNIGHT);
    issue(64'hFFFF_FFFF_FFFF_FFFF, 6'd28, MODE_KNIGHT);
    issue(64'h0, 6'd0, MODE_KING);
    issue(64'hFFFF_FFFF_FFFF_FFFF, 6'd63, MODE_KING);
    issue(64'h0, 6'd35, MODE_KING);
    // Pawns on the first and last rank and on the edge files.
    issue(64'h0, 6'd3, MODE_WHITE_PAWN);
    issue(64'h0, 6'd60, MODE_WHITE_PAWN);
    issue(64'h0, 6'd8, MODE_WHITE_PAWN);
    issue(64'h0, 6'd4, MODE_BLACK_PAWN);
    issue(64'h0, 6'd63, MODE_BLACK_PAWN);
    issue(64'h0, 6'd55, MODE_BLACK_PAWN);
    // Unused mode must give an empty set whatever the board.
    issue(64'h0123_4567_89AB_CDEF, 6'd20, MODE_UNUSED);
    issue(64'hFFFF_FFFF_FFFF_FFFF, 6'd0, MODE_UNUSED);

    // --- random part -------------------------------------------------------
    for (int i = 0; i < 700; i++) begin
      // Every fourth block of 50 runs gap-free, as does the tail of the run.
      quiet = (i >= 600) || ((i / 50) % 4 == 3);
      if (i == 350) drain();
      if (!quiet && $urandom_range(0, 3) == 0) idle($urandom_range(1, 19));

      // Boards from sparse to dense so rays both run long and stop short.
      case ($urandom_range(0, 4))
        0:       occ = {$urandom, $urandom};
        1:       occ = {$urandom, $urandom} & {$urandom, $urandom};
        2:       occ = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        3:       occ = {$urandom, $urandom} | {$urandom, $urandom};
        default: occ = ($urandom_range(0, 1) == 0) ? 64'h0 : {$urandom, $urandom} &
                       {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      endcase
      sq = square_t'($urandom_range(0, 63));
      // Favor the sliders, which carry most of the logic.
      if ($urandom_range(0, 9) < 6) md = mode_t'($urandom_range(0, 2));
      else md = mode_t'($urandom_range(0, 7));
      issue(occ, sq, md);
    end
    start <= 1'b0;

    // Let the pipeline empty, then watch a little longer.
    do @(posedge clk); while (outstanding != 0);
    repeat (TailCycles) @(posedge clk);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/cpag_pkg.sv
hdl/cpag_slider.sv
hdl/cpag_leaper.sv
hdl/chess_piece_attack_generator.sv
tb/attack_checker.sv
tb/tb.sv
